>>> hw/rtl/dtc4m_pkg.sv
// shared types and constants for the dual timer counter block
// no dependencies; imported by the top level and its checker

package dtc4m_pkg;

   // stream widths
   localparam int unsigned ReqDataWidth = 24;
   localparam int unsigned RspDataWidth = 40;
   localparam int unsigned TickWidth    = 7;

   // register byte select codes for a write transaction
   localparam logic [2:0] SEL_LOW0    = 3'd0;
   localparam logic [2:0] SEL_HIGH0   = 3'd1;
   localparam logic [2:0] SEL_LOW1    = 3'd2;
   localparam logic [2:0] SEL_HIGH1   = 3'd3;
   localparam logic [2:0] SEL_CONTROL = 3'd4;

   // command codes
   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_WRITE   = 1'b1;

   // timer mode codes
   localparam logic [1:0] MODE_13BIT  = 2'd0;
   localparam logic [1:0] MODE_16BIT  = 2'd1;
   localparam logic [1:0] MODE_RELOAD = 2'd2;
   localparam logic [1:0] MODE_SPLIT  = 2'd3;

   // control byte bit positions
   localparam int unsigned BIT_RUN0  = 4;
   localparam int unsigned BIT_FLAG0 = 5;
   localparam int unsigned BIT_RUN1  = 6;
   localparam int unsigned BIT_FLAG1 = 7;

   // csr register word index
   localparam logic REG_TIMER_MODES = 1'b0;

   // reciprocal for a divide by 3 of an 8-bit value
   localparam logic [7:0] RECIP3 = 8'd171;

   typedef struct packed {
      logic [7:0] lo;
      logic [7:0] hi;
      logic       ovf;
   } tmr_res_type;

endpackage

>>> hw/rtl/dual_timer_counter_four_modes_unit.sv
// dual timer counter with four modes, top level
// depends on dtc4m_pkg
//
// channel   direction  handshake               payload
// req       in         req_tvalid/req_tready   tdata: cycles, reg_select, write_value; tuser: command
// rsp       out        rsp_tvalid/rsp_tready   tdata: low0, high0, low1, high1, control
// csr       in         csr_psel/csr_penable    timer_modes at byte address 0
//
// one transaction per cycle while rsp is not stalled; each passes the input register, then the
// result register; the input register holds the tick count (cycles / 12, min one), the timer update
// runs between it and the result register, which also holds the timer state
// a stalled rsp holds its result; the input register still takes one more transaction
// reset clears the timers, control byte, mode register and both valid bits

module dual_timer_counter_four_modes_unit (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: [9:0] cycles, [12:10] reg_select, [20:13] write_value, zero pad
   input  logic [dtc4m_pkg::ReqDataWidth-1:0]  req_tdata,
   // tuser: [0] command
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [7:0] low0, [15:8] high0, [23:16] low1, [31:24] high1, [39:32] control
   output logic [dtc4m_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import dtc4m_pkg::*;

   // csr
   logic [7:0] modes_ff, modes_in;
   logic       csr_wr;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_cmd_ff;
   logic [TickWidth-1:0] s1_ticks_ff;
   logic [2:0]           s1_sel_ff;
   logic [7:0]           s1_val_ff;

   // timer state and result register
   logic [7:0] low0_ff, low0_in, high0_ff, high0_in;
   logic [7:0] low1_ff, low1_in, high1_ff, high1_in;
   logic [7:0] ctl_ff, ctl_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // handshake
   logic out_load, s1_adv, req_acc;

   // divide by 12 as (cycles >> 2) / 3
   logic [7:0]           cyc_div4;
   logic [15:0]          div_prod;
   logic [TickWidth-1:0] quot, ticks;

   logic [1:0]  m0, m1;
   logic [8:0]  sum_lo0, sum_hi0;
   tmr_res_type res0, res1;

   function automatic tmr_res_type run_timer(input logic [1:0]           mode,
                                             input logic [7:0]           lo,
                                             input logic [7:0]           hi,
                                             input logic [TickWidth-1:0] tk);
      logic [16:0] c16;
      logic [13:0] c13;
      logic [8:0]  c8;
      tmr_res_type r;
      r.lo = lo;
      r.hi = hi;
      r.ovf = 1'b0;
      c16 = {1'b0, hi, lo} + 17'(tk);
      c13 = {1'b0, hi, lo[4:0]} + 14'(tk);
      c8 = {1'b0, lo} + 9'(tk);
      case (mode)
         MODE_13BIT: begin
            r.hi = c13[12:5];
            r.lo = {3'b000, c13[4:0]};
            r.ovf = c13[13];
         end
         MODE_16BIT: begin
            r.hi = c16[15:8];
            r.lo = c16[7:0];
            r.ovf = c16[16];
         end
         MODE_RELOAD: begin
            // one overflow per step, remainder added to the reload byte
            r.ovf = c8[8];
            r.lo = c8[8] ? (hi + c8[7:0]) : c8[7:0];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_TIMER_MODES);
   assign csr_prdata = (csr_paddr[2] == REG_TIMER_MODES) ? {24'd0, modes_ff} : 32'd0;
   assign modes_in = csr_wr ? csr_pwdata[7:0] : modes_ff;

   // handshake
   assign out_load = !rsp_valid_ff || rsp_tready;
   assign s1_adv = s1_valid_ff && out_load;
   assign req_tready = !s1_valid_ff || out_load;
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // exact for 8-bit dividends
   assign cyc_div4 = req_tdata[9:2];
   assign div_prod = 16'(cyc_div4) * 16'(RECIP3);
   assign quot = div_prod[15:9];
   assign ticks = (quot == '0) ? TickWidth'(1) : quot;

   // timer update
   assign m0 = modes_ff[1:0];
   assign m1 = modes_ff[5:4];
   assign sum_lo0 = {1'b0, low0_ff} + 9'(s1_ticks_ff);
   assign sum_hi0 = {1'b0, high0_ff} + 9'(s1_ticks_ff);
   assign res0 = run_timer(m0, low0_ff, high0_ff, s1_ticks_ff);
   assign res1 = run_timer(m1, low1_ff, high1_ff, s1_ticks_ff);

   always_comb begin
      low0_in = low0_ff;
      high0_in = high0_ff;
      low1_in = low1_ff;
      high1_in = high1_ff;
      ctl_in = ctl_ff;
      if (s1_adv) begin
         if (s1_cmd_ff == CMD_WRITE) begin
            case (s1_sel_ff)
               SEL_LOW0:    low0_in = s1_val_ff;
               SEL_HIGH0:   high0_in = s1_val_ff;
               SEL_LOW1:    low1_in = s1_val_ff;
               SEL_HIGH1:   high1_in = s1_val_ff;
               SEL_CONTROL: ctl_in = s1_val_ff;
               default: begin
               end
            endcase
         end else if (m0 == MODE_SPLIT) begin
            // split mode: both bytes of timer 0 run, timer 1 frozen
            if (ctl_ff[BIT_RUN0]) begin
               low0_in = sum_lo0[7:0];
               if (sum_lo0[8]) ctl_in[BIT_FLAG0] = 1'b1;
            end
            if (ctl_ff[BIT_RUN1]) begin
               high0_in = sum_hi0[7:0];
               if (sum_hi0[8]) ctl_in[BIT_FLAG1] = 1'b1;
            end
         end else begin
            if (ctl_ff[BIT_RUN0]) begin
               low0_in = res0.lo;
               high0_in = res0.hi;
               if (res0.ovf) ctl_in[BIT_FLAG0] = 1'b1;
            end
            if (ctl_ff[BIT_RUN1]) begin
               low1_in = res1.lo;
               high1_in = res1.hi;
               if (res1.ovf) ctl_in[BIT_FLAG1] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low0_ff <= '0;
         high0_ff <= '0;
         low1_ff <= '0;
         high1_ff <= '0;
         ctl_ff <= '0;
      end else begin
         modes_ff <= modes_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         low0_ff <= low0_in;
         high0_ff <= high0_in;
         low1_ff <= low1_in;
         high1_ff <= high1_in;
         ctl_ff <= ctl_in;
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff <= req_tuser;
         s1_ticks_ff <= ticks;
         s1_sel_ff <= req_tdata[12:10];
         s1_val_ff <= req_tdata[20:13];
      end
   end

   // the state registers are the result payload
   assign rsp_tdata = {ctl_ff, high1_ff, low1_ff, high0_ff, low0_ff};
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hw/rtl/dtc4m_checker.sv
// port-level checker for the dual timer counter block, with its bind
// depends on dtc4m_pkg and dual_timer_counter_four_modes_unit

module dtc4m_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [dtc4m_pkg::RspDataWidth-1:0]  rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic                                csr_pready
);
   import dtc4m_pkg::*;

   // stalled result holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // csr port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr pready low");

   // one slot of buffering only: accepting while rsp is stalled fills it
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> !req_tready || rsp_tready)
      else $error("req taken with no room behind a stalled rsp");

endmodule

bind dual_timer_counter_four_modes_unit dtc4m_checker u_dtc4m_checker (.*);

>>> test/testbench.sv
// self-checking bench for the dual timer counter block, four timer modes
// depends on dtc4m_pkg and dual_timer_counter_four_modes_unit
// drives advance and write transactions, predicts every result and compares it byte by byte

module testbench;
   import dtc4m_pkg::*;

   localparam int unsigned StallLimit = 2000;
   localparam int unsigned LongHold   = 80;
   localparam int unsigned PhaseOps   = 60;

   typedef struct packed {
      logic       cmd;
      logic [9:0] cycles;
      logic [2:0] sel;
      logic [7:0] value;
   } timer_op_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [2:0]               csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // predicted block state
   logic [7:0] cnt_low0, cnt_high0, cnt_low1, cnt_high1, ctrl_reg, timer_mode_q;

   timer_op_type            pending_ops[$];
   logic [RspDataWidth-1:0] expected_counts[$];
   int                      issued = 0;
   int                      accepted = 0;
   int                      errors = 0;
   int                      stall_cycles = 0;
   int                      send_gap = 0;
   int                      hold_left = 0;
   logic                    req_fire = 1'b0;
   logic                    quiet = 1'b0;
   logic                    long_hold_req = 1'b0;
   logic                    long_hold_done = 1'b0;
   string                   field_names[5] = '{"low0", "high0", "low1", "high1", "control"};
   logic [7:0]              phase_modes[8] = '{8'h00, 8'hFF, 8'h13, 8'h31,
                                              8'h20, 8'h02, 8'h12, 8'h23};

   dual_timer_counter_four_modes_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic step_byte(inout logic [7:0] b, input int ticks, input int flag_bit);
      int c;
      c = b + ticks;
      if (c > 'hFF) ctrl_reg[flag_bit] = 1'b1;
      b = c[7:0];
   endtask

   task automatic step_timer(input logic [1:0] mode, inout logic [7:0] lo,
                             inout logic [7:0] hi, input int ticks, input int flag_bit);
      int c;
      case (mode)
         MODE_16BIT: begin
            c = {hi, lo} + ticks;
            if (c > 'hFFFF) ctrl_reg[flag_bit] = 1'b1;
            hi = c[15:8];
            lo = c[7:0];
         end
         MODE_13BIT: begin
            c = {hi, lo[4:0]} + ticks;
            if (c > 'h1FFF) ctrl_reg[flag_bit] = 1'b1;
            hi = c[12:5];
            lo = {3'b000, c[4:0]};
         end
         MODE_RELOAD: begin
            // one reload per step, the spill adds onto the reload byte
            c = lo + ticks;
            if (c > 'hFF) begin
               ctrl_reg[flag_bit] = 1'b1;
               c = hi + c - 'h100;
            end
            lo = c[7:0];
         end
         default: ;
      endcase
   endtask

   task automatic apply_timer_op(input timer_op_type op);
      int         ticks;
      logic [1:0] m0, m1;
      if (op.cmd == CMD_WRITE) begin
         case (op.sel)
            SEL_LOW0:    cnt_low0 = op.value;
            SEL_HIGH0:   cnt_high0 = op.value;
            SEL_LOW1:    cnt_low1 = op.value;
            SEL_HIGH1:   cnt_high1 = op.value;
            SEL_CONTROL: ctrl_reg = op.value;
            default: ;
         endcase
      end else begin
         ticks = op.cycles / 12;
         if (ticks == 0) ticks = 1;
         m0 = timer_mode_q[1:0];
         m1 = timer_mode_q[5:4];
         if (m0 == MODE_SPLIT) begin
            // timer 1 is frozen while timer 0 is split
            if (ctrl_reg[BIT_RUN0]) step_byte(cnt_low0, ticks, BIT_FLAG0);
            if (ctrl_reg[BIT_RUN1]) step_byte(cnt_high0, ticks, BIT_FLAG1);
         end else begin
            if (ctrl_reg[BIT_RUN0]) step_timer(m0, cnt_low0, cnt_high0, ticks, BIT_FLAG0);
            if (ctrl_reg[BIT_RUN1]) step_timer(m1, cnt_low1, cnt_high1, ticks, BIT_FLAG1);
         end
      end
   endtask

   task automatic send_op(input logic cmd, input logic [9:0] cyc, input logic [2:0] sel,
                          input logic [7:0] val);
      timer_op_type op;
      op.cmd = cmd;
      op.cycles = cyc;
      op.sel = sel;
      op.value = val;
      pending_ops.push_back(op);
      issued++;
   endtask

   task automatic write_modes(input logic [7:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_TIMER_MODES, 2'b00};
      csr_pwdata <= {24'h0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      timer_mode_q = v;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (accepted != issued || expected_counts.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      timer_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 16);
            req_tvalid <= 1'b0;
         end else begin
            op = pending_ops.pop_front();
            req_tdata <= {3'b000, op.value, op.sel, op.cycles};
            req_tuser <= op.cmd;
            req_tvalid <= 1'b1;
         end
      end
   end

   // result receiver with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = LongHold - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on request, compare on result
   always @(posedge clock) begin
      timer_op_type            op;
      logic [RspDataWidth-1:0] want;
      if (reset) begin
         req_fire <= 1'b0;
         cnt_low0 = '0;
         cnt_high0 = '0;
         cnt_low1 = '0;
         cnt_high1 = '0;
         ctrl_reg = '0;
         timer_mode_q = '0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            op.cmd = req_tuser;
            op.cycles = req_tdata[9:0];
            op.sel = req_tdata[12:10];
            op.value = req_tdata[20:13];
            apply_timer_op(op);
            expected_counts.push_back({ctrl_reg, cnt_high1, cnt_low1, cnt_high0, cnt_low0});
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_counts.pop_front();
               for (int i = 0; i < 5; i++) begin
                  if (rsp_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                     $display("%0t: %s expected %h actual %h", $time, field_names[i],
                              want[8*i +: 8], rsp_tdata[8*i +: 8]);
                     errors++;
                  end
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int         roll;
      logic [9:0] cyc;
      logic [7:0] val;
      logic [1:0] m;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all-ones counts overflowing in each mode
      for (int k = 0; k < 4; k++) begin
         m = k[1:0];
         wait_drained();
         write_modes({2'b00, m, 2'b00, m});
         send_op(CMD_WRITE, 10'h000, SEL_LOW0, 8'hFF);
         send_op(CMD_WRITE, 10'h3FF, SEL_HIGH0, 8'hFF);
         send_op(CMD_WRITE, 10'h000, SEL_LOW1, 8'hFF);
         send_op(CMD_WRITE, 10'h3FF, SEL_HIGH1, 8'hFF);
         send_op(CMD_WRITE, 10'h000, SEL_CONTROL, 8'h5A);
         send_op(CMD_ADVANCE, 10'h3FF, 3'd7, 8'hFF);
      end
      send_op(CMD_ADVANCE, 10'h000, SEL_LOW0, 8'h00);
      send_op(CMD_WRITE, 10'h155, 3'd7, 8'hFF);
      send_op(CMD_WRITE, 10'h2AA, SEL_CONTROL, 8'h0F);
      send_op(CMD_ADVANCE, 10'd12, SEL_CONTROL, 8'h55);

      for (int p = 0; p < 10; p++) begin
         wait_drained();
         write_modes(p < 8 ? phase_modes[p] : 8'($urandom_range(0, 255)));
         quiet = (p >= 8);
         for (int k = 0; k < PhaseOps; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: cyc = 10'($urandom_range(0, 47));
                  3, 4:    cyc = 10'($urandom_range(0, 1023));
                  default: cyc = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
               endcase
               send_op(CMD_ADVANCE, cyc, 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)));
            end else if (roll < 70) begin
               // mostly keep the timers running
               val = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 3) != 0) val[BIT_RUN0] = 1'b1;
               if ($urandom_range(0, 3) != 0) val[BIT_RUN1] = 1'b1;
               send_op(CMD_WRITE, 10'($urandom_range(0, 1023)), SEL_CONTROL, val);
            end else if (roll < 92) begin
               // counts near the top so overflows come often
               val = $urandom_range(0, 2) ? 8'($urandom_range(8'hE0, 8'hFF))
                                          : 8'($urandom_range(0, 255));
               send_op(CMD_WRITE, 10'($urandom_range(0, 1023)),
                       3'($urandom_range(SEL_LOW0, SEL_HIGH1)), val);
            end else begin
               send_op(CMD_WRITE, 10'($urandom_range(0, 1023)),
                       3'($urandom_range(SEL_CONTROL + 1, 7)), 8'($urandom_range(0, 255)));
            end
         end
         if (p == 2) long_hold_req = 1'b1;
      end

      wait_drained();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
